// ===== src/afc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_pkg
// Shared types and codes of the box-against-planes classifier.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned INDEX_W = 3;
    localparam int unsigned CLASS_W = 2;

    localparam logic [CLASS_W-1:0] CLASS_INSIDE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_INTERSECT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OUTSIDE   = 2'd2;

    localparam logic MODE_PLANE = 1'b0;
    localparam logic MODE_BOX   = 1'b1;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic               is_box;
        logic [INDEX_W-1:0] index;
        coord_t             nx;
        coord_t             ny;
        coord_t             nz;
        coord_t             d;
        coord_t             lo_x;
        coord_t             lo_y;
        coord_t             lo_z;
        coord_t             hi_x;
        coord_t             hi_y;
        coord_t             hi_z;
    } cmd_t;

endpackage

// ===== src/afc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_front
// Input stage: accepts items, drops out-of-range plane loads, and hands
// commands to the queue.
// ----------------------------------------------------------------------------
module afc_front #(
    parameter int unsigned MAX_PLANES = 6
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  afc_pkg::cmd_t                in_cmd,
    output logic                         push,
    output afc_pkg::cmd_t                push_cmd,
    input  logic                         q_full
);
    import afc_pkg::*;

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    logic accept;
    logic keep;

    assign in_stall = valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    // drop plane loads aimed past the table
    assign keep = in_cmd.is_box || ({27'd0, in_cmd.index} < 32'(MAX_PLANES));

    always_comb
    begin
        valid_next = valid_reg && !push;
        if (accept && keep)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_cmd;
        end
    end

endmodule

// ===== src/afc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_queue
// Two-entry command queue between the input stage and the engine.
// ----------------------------------------------------------------------------
module afc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  afc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output afc_pkg::cmd_t pop_cmd,
    output logic          full,
    output logic          empty
);
    import afc_pkg::*;

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/afc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afc_engine
// Plane table and box test: one plane per cycle through a multiply/add
// pipeline (stages a, b and c), all eight corners in parallel.
// ----------------------------------------------------------------------------
module afc_engine #(
    parameter int unsigned MAX_PLANES = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [afc_pkg::COUNT_W-1:0]     plane_count,
    input  logic                            q_empty,
    input  afc_pkg::cmd_t                   q_cmd,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [afc_pkg::CLASS_W-1:0]     box_class
);
    import afc_pkg::*;

    localparam int unsigned IW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t               state_reg;
    logic [COUNT_W-1:0]   iss_cnt_reg;
    logic [COUNT_W-1:0]   n_planes;
    logic                 issue;
    logic                 out_valid_reg;
    logic [CLASS_W-1:0]   class_reg;
    logic [CLASS_W-1:0]   result_reg;
    logic                 outside_reg;
    logic                 seen_out_reg;
    logic                 slot_free;

    coord_t tbl_nx [MAX_PLANES];
    coord_t tbl_ny [MAX_PLANES];
    coord_t tbl_nz [MAX_PLANES];
    coord_t tbl_d  [MAX_PLANES];

    coord_t lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;

    logic   a_v_reg, a_last_reg, b_v_reg, b_last_reg, c_v_reg, c_last_reg;
    coord_t a_nx_reg, a_ny_reg, a_nz_reg, a_d_reg;

    logic signed [63:0] b_px_reg [2];
    logic signed [63:0] b_py_reg [2];
    logic signed [63:0] b_pz_reg [2];
    logic signed [65:0] b_d_reg;

    logic signed [65:0] c_xyd_reg [4];
    logic signed [63:0] c_pz_reg  [2];

    logic signed [65:0] corner_sum [8];
    logic [7:0] front;
    logic       any_in;
    logic       any_out;
    logic       plane_write;

    assign n_planes   = (32'(plane_count) > 32'(MAX_PLANES)) ?
                        COUNT_W'(MAX_PLANES) : plane_count;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign pop        = (state_reg == S_IDLE) && !q_empty;
    assign plane_write = pop && !q_cmd.is_box;
    assign issue      = (state_reg == S_RUN) && (iss_cnt_reg < n_planes);
    assign out_valid  = out_valid_reg;
    assign box_class  = class_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            corner_sum[k] = c_xyd_reg[k % 4] + 66'(c_pz_reg[k / 4]);
            front[k]      = !corner_sum[k][65];
        end
    end

    assign any_in  = |front;
    assign any_out = ~&front;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            outside_reg   <= 1'b0;
            seen_out_reg  <= 1'b0;
            a_v_reg       <= 1'b0;
            b_v_reg       <= 1'b0;
            c_v_reg       <= 1'b0;
            a_last_reg    <= 1'b0;
            b_last_reg    <= 1'b0;
            c_last_reg    <= 1'b0;
            class_reg     <= CLASS_INSIDE;
            result_reg    <= CLASS_INSIDE;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            a_v_reg    <= issue;
            a_last_reg <= issue && (iss_cnt_reg == n_planes - COUNT_W'(1));
            b_v_reg    <= a_v_reg;
            b_last_reg <= a_last_reg;
            c_v_reg    <= b_v_reg;
            c_last_reg <= b_last_reg;
            if (issue)
            begin
                iss_cnt_reg <= iss_cnt_reg + COUNT_W'(1);
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop && q_cmd.is_box)
                    begin
                        iss_cnt_reg  <= '0;
                        outside_reg  <= 1'b0;
                        seen_out_reg <= 1'b0;
                        if (n_planes == '0)
                        begin
                            result_reg <= CLASS_INSIDE;
                            state_reg  <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_RUN;
                        end
                    end
                end
                S_RUN:
                begin
                    if (c_v_reg)
                    begin
                        outside_reg  <= outside_reg || !any_in;
                        seen_out_reg <= seen_out_reg || any_out;
                        if (c_last_reg)
                        begin
                            if (outside_reg || !any_in)
                            begin
                                result_reg <= CLASS_OUTSIDE;
                            end
                            else if (seen_out_reg || any_out)
                            begin
                                result_reg <= CLASS_INTERSECT;
                            end
                            else
                            begin
                                result_reg <= CLASS_INSIDE;
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        class_reg     <= result_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (plane_write)
        begin
            tbl_nx[IW'(q_cmd.index)] <= q_cmd.nx;
            tbl_ny[IW'(q_cmd.index)] <= q_cmd.ny;
            tbl_nz[IW'(q_cmd.index)] <= q_cmd.nz;
            tbl_d[IW'(q_cmd.index)]  <= q_cmd.d;
        end
        if (pop && q_cmd.is_box)
        begin
            lo_x_reg <= q_cmd.lo_x;
            lo_y_reg <= q_cmd.lo_y;
            lo_z_reg <= q_cmd.lo_z;
            hi_x_reg <= q_cmd.hi_x;
            hi_y_reg <= q_cmd.hi_y;
            hi_z_reg <= q_cmd.hi_z;
        end
        a_nx_reg <= tbl_nx[IW'(iss_cnt_reg)];
        a_ny_reg <= tbl_ny[IW'(iss_cnt_reg)];
        a_nz_reg <= tbl_nz[IW'(iss_cnt_reg)];
        a_d_reg  <= tbl_d[IW'(iss_cnt_reg)];

        b_px_reg[0] <= 64'(a_nx_reg) * 64'(lo_x_reg);
        b_px_reg[1] <= 64'(a_nx_reg) * 64'(hi_x_reg);
        b_py_reg[0] <= 64'(a_ny_reg) * 64'(lo_y_reg);
        b_py_reg[1] <= 64'(a_ny_reg) * 64'(hi_y_reg);
        b_pz_reg[0] <= 64'(a_nz_reg) * 64'(lo_z_reg);
        b_pz_reg[1] <= 64'(a_nz_reg) * 64'(hi_z_reg);
        b_d_reg     <= {{18{a_d_reg[COORD_W-1]}}, a_d_reg, 16'd0};

        for (int j = 0; j < 4; j++)
        begin
            c_xyd_reg[j] <= 66'(b_px_reg[j % 2]) + 66'(b_py_reg[j / 2]) + b_d_reg;
        end
        c_pz_reg[0] <= b_pz_reg[0];
        c_pz_reg[1] <= b_pz_reg[1];
    end

endmodule

// ===== src/aabb_frustum_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_frustum_classifier
// Classifies axis-aligned boxes against a table of clipping planes.
// ----------------------------------------------------------------------------
// A plane-load item (mode 0) with an index below MAX_PLANES writes one table
// entry and gives no result; a box item (mode 1) gives one box_class: 0
// inside, 1 intersecting, 2 outside. With n the plane_count capped at
// MAX_PLANES, a box holds the engine while its n planes go one per cycle
// through a multiply/add pipeline (stages a, b and c), all eight corners at
// once; its registered box_class goes valid once the planes are done and
// the output is not stalled. A plane load is written into the table as it
// leaves the queue. The input stage and a two-entry queue absorb items while
// the engine is busy; in_stall rises once both are full. The plane table is
// undefined until written; only write plane_count while the block is idle.
module aabb_frustum_classifier #(
    parameter int unsigned MAX_PLANES = 6
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [afc_pkg::COUNT_W-1:0]        cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               mode,
    input  logic [afc_pkg::INDEX_W-1:0]        plane_index,
    input  logic signed [afc_pkg::COORD_W-1:0] normal_x,
    input  logic signed [afc_pkg::COORD_W-1:0] normal_y,
    input  logic signed [afc_pkg::COORD_W-1:0] normal_z,
    input  logic signed [afc_pkg::COORD_W-1:0] plane_offset,
    input  logic signed [afc_pkg::COORD_W-1:0] min_x,
    input  logic signed [afc_pkg::COORD_W-1:0] min_y,
    input  logic signed [afc_pkg::COORD_W-1:0] min_z,
    input  logic signed [afc_pkg::COORD_W-1:0] max_x,
    input  logic signed [afc_pkg::COORD_W-1:0] max_y,
    input  logic signed [afc_pkg::COORD_W-1:0] max_z,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [afc_pkg::CLASS_W-1:0]        box_class
);
    import afc_pkg::*;

    logic [COUNT_W-1:0] plane_count_reg;
    cmd_t               in_cmd;
    cmd_t               push_cmd;
    cmd_t               pop_cmd;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;

    always_comb
    begin
        in_cmd.is_box = (mode == MODE_BOX);
        in_cmd.index  = plane_index;
        in_cmd.nx     = normal_x;
        in_cmd.ny     = normal_y;
        in_cmd.nz     = normal_z;
        in_cmd.d      = plane_offset;
        in_cmd.lo_x   = min_x;
        in_cmd.lo_y   = min_y;
        in_cmd.lo_z   = min_z;
        in_cmd.hi_x   = max_x;
        in_cmd.hi_y   = max_y;
        in_cmd.hi_z   = max_z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_count_reg <= COUNT_W'(6);
        end
        else if (cfg_wr_en)
        begin
            plane_count_reg <= cfg_wr_data;
        end
    end

    afc_front #(
        .MAX_PLANES (MAX_PLANES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_cmd   (in_cmd),
        .push     (q_push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    afc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .full     (q_full),
        .empty    (q_empty)
    );

    afc_engine #(
        .MAX_PLANES (MAX_PLANES)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .plane_count (plane_count_reg),
        .q_empty     (q_empty),
        .q_cmd       (pop_cmd),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .box_class   (box_class)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (box_class == CLASS_INSIDE || box_class == CLASS_INTERSECT ||
                       box_class == CLASS_OUTSIDE))
        else $error("illegal box class");

endmodule
